// ----- hdl/kpt_pkg.sv -----
// Package for the keyed parent table: operation and status codes, field widths
// and the cap on results per lookup. No dependencies.
package kpt_pkg;

	localparam int DataW = 32;
	localparam int MaxResults = 16;
	localparam int MatchCntW = $clog2(MaxResults + 1);

	localparam logic [1:0] FnInsert = 2'd0;
	localparam logic [1:0] FnFindKey = 2'd1;
	localparam logic [1:0] FnFindParent = 2'd2;
	localparam logic [1:0] FnDelete = 2'd3;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StDup = 2'd1;
	localparam logic [1:0] StFull = 2'd2;
	localparam logic [1:0] StNotFound = 2'd3;

endpackage

// ----- hdl/kpt_op_if.sv -----
// Operation channel of the keyed parent table: valid/ready handshake and one
// operation per beat. Depends on kpt_pkg.
interface kpt_op_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [kpt_pkg::DataW-1:0] key_in;
	logic [kpt_pkg::DataW-1:0] parent_in;
	logic [kpt_pkg::DataW-1:0] info_in;

	modport source (output valid, func, key_in, parent_in, info_in, input ready);
	modport sink (input valid, func, key_in, parent_in, info_in, output ready);
endinterface

// ----- hdl/kpt_res_if.sv -----
// Result channel of the keyed parent table: valid/ready handshake and one
// result per beat. Depends on kpt_pkg.
interface kpt_res_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [kpt_pkg::DataW-1:0] key_out;
	logic [kpt_pkg::DataW-1:0] parent_out;
	logic [kpt_pkg::DataW-1:0] info_out;
	logic last;

	modport source (output valid, status, key_out, parent_out, info_out, last, input ready);
	modport sink (input valid, status, key_out, parent_out, info_out, last, output ready);
endinterface

// ----- hdl/keyed_parent_table.sv -----
// Keyed parent table top level: entry memory, scan sequencer and result register.
// Depends on kpt_pkg, kpt_op_if and kpt_res_if.
//
// The table holds up to DEPTH entries in one synchronous memory with a single
// read port, and every operation scans the stored entries one read per cycle
// while the scan is not stalled or paused for a delete; a lookup stops early
// once it has MaxResults matches. An operation runs through the accepting
// cycle, one read per entry, draining the read and closing the scan, and
// loading the final result. For each entry it removes, a delete moves the last
// entry into the freed slot and then reads that slot again. A lookup waits
// whenever a matching result cannot be handed over because the previous result
// beat has not been taken, and the final result waits in the same way. A new
// operation is taken once the final result of the previous one sits in the
// output register. No clearing pass is needed after reset.
module keyed_parent_table #(
	parameter int DEPTH = 16,
	parameter int WORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	kpt_op_if.sink op,
	kpt_res_if.source res
);

	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam int EntW = 3 * WORD_WIDTH;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MOVE_RD = 3'd2;
	localparam logic [2:0] S_MOVE_WR = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [EntW-1:0] mem [DEPTH];

	logic [2:0] state_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] scan_idx_q;
	logic [1:0] func_q;
	logic [WORD_WIDTH-1:0] key_q;
	logic [WORD_WIDTH-1:0] parent_q;
	logic [WORD_WIDTH-1:0] info_q;
	logic dup_q;
	logic par_found_q;
	logic found_q;
	logic stop_q;
	logic [kpt_pkg::MatchCntW-1:0] nmatch_q;
	logic pend_valid_q;
	logic [EntW-1:0] pend_q;
	logic [IdxW-1:0] del_idx_q;

	logic rd_valid_s1;
	logic [IdxW-1:0] rd_idx_s1;
	logic [EntW-1:0] rd_data_s1;

	logic res_valid_q;
	logic [1:0] res_status_q;
	logic [kpt_pkg::DataW-1:0] res_key_q;
	logic [kpt_pkg::DataW-1:0] res_parent_q;
	logic [kpt_pkg::DataW-1:0] res_info_q;
	logic res_last_q;

	logic [WORD_WIDTH-1:0] ent_key;
	logic [WORD_WIDTH-1:0] ent_parent;
	logic [WORD_WIDTH-1:0] probe;
	logic [WORD_WIDTH-1:0] want;
	logic [CntW-1:0] count_m1;
	logic is_find;
	logic is_full;
	logic hit;
	logic find_hit;
	logic res_free;
	logic stall;
	logic find_stop;
	logic del_hit;
	logic issue;
	logic scan_done;
	logic push_pend;
	logic finish;
	logic ins_ok;
	logic rd_en;
	logic [IdxW-1:0] rd_addr;
	logic mem_we;
	logic [IdxW-1:0] wr_addr;
	logic [EntW-1:0] wr_data;

	assign ent_key = rd_data_s1[EntW-1 -: WORD_WIDTH];
	assign ent_parent = rd_data_s1[2*WORD_WIDTH-1 -: WORD_WIDTH];
	assign is_find = func_q inside {kpt_pkg::FnFindKey, kpt_pkg::FnFindParent};
	assign probe = (func_q == kpt_pkg::FnFindParent) ? ent_parent : ent_key;
	assign want = (func_q == kpt_pkg::FnFindParent) ? parent_q : key_q;
	assign count_m1 = count_q - CntW'(1);
	assign is_full = (count_q == CntW'(DEPTH));

	assign hit = (state_q == S_SCAN) && rd_valid_s1 && (probe == want);
	assign find_hit = hit && is_find;
	assign res_free = !res_valid_q || res.ready;
	assign stall = find_hit && pend_valid_q && !res_free;
	assign find_stop = find_hit && !stall
		&& (nmatch_q == kpt_pkg::MatchCntW'(kpt_pkg::MaxResults - 1));
	assign del_hit = hit && (func_q == kpt_pkg::FnDelete);
	assign issue = (state_q == S_SCAN) && !stop_q && (scan_idx_q < count_q)
		&& !stall && !find_stop && !del_hit;
	assign scan_done = (state_q == S_SCAN) && !rd_valid_s1
		&& (stop_q || (scan_idx_q >= count_q));
	assign push_pend = find_hit && pend_valid_q && res_free;
	assign finish = (state_q == S_FINISH) && res_free;
	assign ins_ok = (func_q == kpt_pkg::FnInsert) && !dup_q && !is_full;

	assign rd_en = issue || (state_q == S_MOVE_RD);
	assign rd_addr = (state_q == S_MOVE_RD) ? count_m1[IdxW-1:0] : scan_idx_q[IdxW-1:0];
	assign mem_we = (state_q == S_MOVE_WR) || (finish && ins_ok);
	assign wr_addr = (state_q == S_MOVE_WR) ? del_idx_q : count_q[IdxW-1:0];
	assign wr_data = (state_q == S_MOVE_WR) ? rd_data_s1
		: {key_q, (par_found_q ? parent_q : '0), info_q};

	assign op.ready = (state_q == S_IDLE);
	assign res.valid = res_valid_q;
	assign res.status = res_status_q;
	assign res.key_out = res_key_q;
	assign res.parent_out = res_parent_q;
	assign res.info_out = res_info_q;
	assign res.last = res_last_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_idx_s1 <= scan_idx_q[IdxW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (op.valid && op.ready) begin
			key_q <= WORD_WIDTH'(op.key_in);
			parent_q <= WORD_WIDTH'(op.parent_in);
			info_q <= WORD_WIDTH'(op.info_in);
		end
		if (find_hit && !stall) begin
			pend_q <= rd_data_s1;
		end
		if (del_hit) begin
			del_idx_q <= rd_idx_s1;
		end
		if (push_pend) begin
			res_status_q <= kpt_pkg::StOk;
			res_key_q <= kpt_pkg::DataW'(pend_q[EntW-1 -: WORD_WIDTH]);
			res_parent_q <= kpt_pkg::DataW'(pend_q[2*WORD_WIDTH-1 -: WORD_WIDTH]);
			res_info_q <= kpt_pkg::DataW'(pend_q[WORD_WIDTH-1:0]);
			res_last_q <= 1'b0;
		end else if (finish) begin
			res_key_q <= '0;
			res_parent_q <= '0;
			res_info_q <= '0;
			res_last_q <= 1'b1;
			case (func_q)
				kpt_pkg::FnInsert: begin
					if (dup_q) begin
						res_status_q <= kpt_pkg::StDup;
					end else if (is_full) begin
						res_status_q <= kpt_pkg::StFull;
					end else begin
						res_status_q <= kpt_pkg::StOk;
					end
				end
				kpt_pkg::FnDelete: begin
					res_status_q <= found_q ? kpt_pkg::StOk : kpt_pkg::StNotFound;
				end
				default: begin
					if (pend_valid_q) begin
						res_status_q <= kpt_pkg::StOk;
						res_key_q <= kpt_pkg::DataW'(pend_q[EntW-1 -: WORD_WIDTH]);
						res_parent_q <= kpt_pkg::DataW'(pend_q[2*WORD_WIDTH-1 -: WORD_WIDTH]);
						res_info_q <= kpt_pkg::DataW'(pend_q[WORD_WIDTH-1:0]);
					end else begin
						res_status_q <= kpt_pkg::StNotFound;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_idx_q <= '0;
			func_q <= kpt_pkg::FnInsert;
			dup_q <= 1'b0;
			par_found_q <= 1'b0;
			found_q <= 1'b0;
			stop_q <= 1'b0;
			nmatch_q <= '0;
			pend_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue || (rd_valid_s1 && stall);
			if (push_pend || finish) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (op.valid) begin
						func_q <= op.func;
						scan_idx_q <= '0;
						dup_q <= 1'b0;
						par_found_q <= 1'b0;
						found_q <= 1'b0;
						stop_q <= 1'b0;
						nmatch_q <= '0;
						pend_valid_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + CntW'(1);
					end
					if (rd_valid_s1 && (func_q == kpt_pkg::FnInsert)) begin
						if (ent_key == key_q) begin
							dup_q <= 1'b1;
						end
						if (ent_key == parent_q) begin
							par_found_q <= 1'b1;
						end
					end
					if (find_hit && !stall) begin
						pend_valid_q <= 1'b1;
						nmatch_q <= nmatch_q + kpt_pkg::MatchCntW'(1);
					end
					if (find_stop) begin
						stop_q <= 1'b1;
					end
					if (del_hit) begin
						state_q <= S_MOVE_RD;
					end else if (scan_done) begin
						state_q <= S_FINISH;
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					count_q <= count_m1;
					scan_idx_q <= CntW'(del_idx_q);
					found_q <= 1'b1;
					state_q <= S_SCAN;
				end
				S_FINISH: begin
					if (res_free) begin
						if (ins_ok) begin
							count_q <= count_q + CntW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
